[rtl/eltp_pkg.sv]
// package: parse phases, character codes and widths for the edge list text parser
`timescale 1ns / 1ps

package eltp_pkg;

    // fixed widths of the channel payloads
    localparam int BYTE_WIDTH       = 8;
    localparam int OUT_WIDTH        = 32;
    localparam int ID_WIDTH_DEFAULT = 32;

    // character codes
    localparam logic [BYTE_WIDTH-1:0] CHAR_PERCENT = 8'h25;
    localparam logic [BYTE_WIDTH-1:0] CHAR_HASH    = 8'h23;
    localparam logic [BYTE_WIDTH-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_WIDTH-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_WIDTH-1:0] CHAR_LF      = 8'h0A;
    localparam logic [BYTE_WIDTH-1:0] CHAR_CR      = 8'h0D;
    localparam logic [BYTE_WIDTH-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [BYTE_WIDTH-1:0] CHAR_TAB     = 8'h09;

    // parse phase of the current line
    typedef enum logic [2:0] {
        PH_LINE    = 3'd0,
        PH_DISCARD = 3'd1,
        PH_SKIP1   = 3'd2,
        PH_NUM1    = 3'd3,
        PH_SKIP2   = 3'd4,
        PH_NUM2    = 3'd5
    } phase_t;

endpackage

[rtl/eltp_if.sv]
// interfaces: text byte channel and edge pair channel
`timescale 1ns / 1ps

interface eltp_text_if;
    logic                           valid;
    logic                           ready;
    logic [eltp_pkg::BYTE_WIDTH-1:0] text_byte;
    logic                           end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface eltp_edge_if;
    logic                          valid;
    logic                          ready;
    logic [eltp_pkg::OUT_WIDTH-1:0] source_id;
    logic [eltp_pkg::OUT_WIDTH-1:0] dest_id;

    modport source (output valid, output source_id, output dest_id, input ready);
    modport sink   (input valid, input source_id, input dest_id, output ready);
endinterface

[rtl/edge_list_text_parser_unit.sv]
// top level: edge list text parser, one byte per cycle unless stalled, one edge per edge line
`timescale 1ns / 1ps
// a byte passes the input register, then the result register, before its edge pair is valid
// one byte per cycle when not stalled, with a combinational phase and multiply-by-ten update
// the result register frees the input side while an edge waits to be taken
// reset (rst_n low, asynchronous): phase to line start, both values zero, both registers empty

module edge_list_text_parser_unit #(
    parameter int ID_WIDTH = eltp_pkg::ID_WIDTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    eltp_text_if.sink         text,
    eltp_edge_if.source       edges
);

    // input register
    logic                             in_valid_reg;
    logic [eltp_pkg::BYTE_WIDTH-1:0]  in_byte_reg;
    logic                             in_last_reg;

    // parser state
    eltp_pkg::phase_t                 phase_reg;
    eltp_pkg::phase_t                 phase_step;
    eltp_pkg::phase_t                 phase_next;
    logic [ID_WIDTH-1:0]              first_reg;
    logic [ID_WIDTH-1:0]              first_next;
    logic [ID_WIDTH-1:0]              second_reg;
    logic [ID_WIDTH-1:0]              second_next;

    // result register
    logic                             out_valid_reg;
    logic [eltp_pkg::OUT_WIDTH-1:0]   out_source_reg;
    logic [eltp_pkg::OUT_WIDTH-1:0]   out_dest_reg;

    // byte classification
    logic                             is_digit;
    logic                             is_blank;
    logic                             is_comment;
    logic                             is_newline;
    logic [ID_WIDTH-1:0]              digit_val;
    logic [ID_WIDTH-1:0]              first_acc;
    logic [ID_WIDTH-1:0]              second_acc;

    logic                             emit_line;
    logic                             edge_open;
    logic                             emit;
    logic                             advance;

    assign is_digit   = (in_byte_reg >= eltp_pkg::CHAR_ZERO) &&
                        (in_byte_reg <= eltp_pkg::CHAR_NINE);
    assign is_newline = (in_byte_reg == eltp_pkg::CHAR_LF);
    assign is_blank   = is_newline || (in_byte_reg == eltp_pkg::CHAR_CR) ||
                        (in_byte_reg == eltp_pkg::CHAR_SPACE) ||
                        (in_byte_reg == eltp_pkg::CHAR_TAB);
    assign is_comment = (in_byte_reg == eltp_pkg::CHAR_PERCENT) ||
                        (in_byte_reg == eltp_pkg::CHAR_HASH);

    // digit value is the low nibble of an ascii digit
    assign digit_val  = ID_WIDTH'(in_byte_reg[3:0]);

    // value*10 + digit as two shifts and adds, wrapping at ID_WIDTH
    assign first_acc  = (first_reg << 3) + (first_reg << 1) + digit_val;
    assign second_acc = (second_reg << 3) + (second_reg << 1) + digit_val;

    // next phase for one byte
    always_comb
    begin
        phase_step = phase_reg;
        case (phase_reg)
            eltp_pkg::PH_DISCARD:
            begin
                if (is_newline)
                    phase_step = eltp_pkg::PH_LINE;
            end
            eltp_pkg::PH_SKIP1:
            begin
                if (is_digit)
                    phase_step = eltp_pkg::PH_NUM1;
            end
            eltp_pkg::PH_NUM1:
            begin
                if (!is_digit)
                    phase_step = eltp_pkg::PH_SKIP2;
            end
            eltp_pkg::PH_SKIP2:
            begin
                if (is_digit)
                    phase_step = eltp_pkg::PH_NUM2;
            end
            eltp_pkg::PH_NUM2:
            begin
                if (!is_digit)
                    phase_step = is_newline ? eltp_pkg::PH_LINE : eltp_pkg::PH_DISCARD;
            end
            default:
            begin
                // line start, and any code that is not a phase
                if (is_blank)
                    phase_step = eltp_pkg::PH_LINE;
                else if (is_comment)
                    phase_step = eltp_pkg::PH_DISCARD;
                else if (is_digit)
                    phase_step = eltp_pkg::PH_NUM1;
                else
                    phase_step = eltp_pkg::PH_SKIP1;
            end
        endcase
        // the last byte of a text sends the parser back to line start
        phase_next = in_last_reg ? eltp_pkg::PH_LINE : phase_step;
    end

    // value updates and edge emission
    always_comb
    begin
        first_next  = first_reg;
        second_next = second_reg;
        emit_line   = 1'b0;
        case (phase_reg)
            eltp_pkg::PH_DISCARD:
            begin
                first_next = first_reg;
            end
            eltp_pkg::PH_SKIP1:
            begin
                if (is_digit)
                    first_next = digit_val;
            end
            eltp_pkg::PH_NUM1:
            begin
                if (is_digit)
                    first_next = first_acc;
            end
            eltp_pkg::PH_SKIP2:
            begin
                if (is_digit)
                    second_next = digit_val;
            end
            eltp_pkg::PH_NUM2:
            begin
                if (is_digit)
                    second_next = second_acc;
                else
                    emit_line = 1'b1;
            end
            default:
            begin
                // a new edge opens on anything but a blank or a comment mark
                if (!is_blank && !is_comment)
                begin
                    first_next  = is_digit ? digit_val : '0;
                    second_next = '0;
                end
            end
        endcase
    end

    // an edge still open at end of text goes out with missing values as zero
    assign edge_open = (phase_step == eltp_pkg::PH_SKIP1) ||
                       (phase_step == eltp_pkg::PH_NUM1)  ||
                       (phase_step == eltp_pkg::PH_SKIP2) ||
                       (phase_step == eltp_pkg::PH_NUM2);
    assign emit      = emit_line || (in_last_reg && edge_open);

    // a byte moves on unless it emits while the result register is held
    assign advance    = in_valid_reg && (!emit || !out_valid_reg || edges.ready);
    assign text.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (text.ready)
            in_valid_reg <= text.valid;
    end

    always_ff @(posedge clk)
    begin
        if (text.ready && text.valid)
        begin
            in_byte_reg <= text.text_byte;
            in_last_reg <= text.end_of_text;
        end
    end

    // parser state, cleared again after the last byte of a text
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= eltp_pkg::PH_LINE;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg  <= phase_next;
            first_reg  <= in_last_reg ? '0 : first_next;
            second_reg <= in_last_reg ? '0 : second_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && emit)
            out_valid_reg <= 1'b1;
        else if (edges.ready)
            out_valid_reg <= 1'b0;
    end

    // ids are cut or zero-extended to the output width
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_source_reg <= eltp_pkg::OUT_WIDTH'(first_next);
            out_dest_reg   <= eltp_pkg::OUT_WIDTH'(second_next);
        end
    end

    assign edges.valid     = out_valid_reg;
    assign edges.source_id = out_source_reg;
    assign edges.dest_id   = out_dest_reg;

endmodule

[bench/edge_list_text_parser_unit_tb.sv]
// testbench: edge list text parser, directed and random text with edge pair checking
`timescale 1ns / 1ps

module edge_list_text_parser_unit_tb;

    // bench timing and run length
    localparam int  HALF_PERIOD   = 6;
    localparam int  RESET_CYCLES  = 7;
    localparam int  RANDOM_BYTES  = 1350;
    localparam int  SEGMENTS      = 6;
    localparam int  DRAIN_CYCLES  = 10;
    localparam int  STALL_LIMIT   = 1000;

    // decimal accumulate and a few characters the package does not name
    localparam logic [eltp_pkg::OUT_WIDTH-1:0]  DECIMAL_BASE = 32'd10;
    localparam logic [eltp_pkg::BYTE_WIDTH-1:0] CHAR_COMMA   = 8'h2C;
    localparam logic [eltp_pkg::BYTE_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [eltp_pkg::BYTE_WIDTH-1:0] NUL_BYTE     = 8'h00;
    localparam logic [eltp_pkg::BYTE_WIDTH-1:0] TOP_BYTE     = 8'hFF;
    localparam string                           MAX_ID_TEXT  = "4294967295";

    typedef struct packed {
        logic [eltp_pkg::OUT_WIDTH-1:0] source_id;
        logic [eltp_pkg::OUT_WIDTH-1:0] dest_id;
    } edge_pair_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    eltp_text_if text_ch ();
    eltp_edge_if edge_ch ();

    edge_list_text_parser_unit #(
        .ID_WIDTH (eltp_pkg::ID_WIDTH_DEFAULT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .edges (edge_ch)
    );

    always #HALF_PERIOD clk = ~clk;

    // parser mirror: phase of the current line and both running values
    eltp_pkg::phase_t               parse_state = eltp_pkg::PH_LINE;
    logic [eltp_pkg::OUT_WIDTH-1:0] src_acc     = '0;
    logic [eltp_pkg::OUT_WIDTH-1:0] dst_acc     = '0;

    // edge pairs the parser owes us, oldest first
    edge_pair_t expected_edges[$];

    // bytes of the line being built by the random generator
    logic [eltp_pkg::BYTE_WIDTH-1:0] line_bytes[$];

    int fault_count  = 0;
    int bytes_sent   = 0;
    int quiet_cycles = 0;

    // sender idling: bursts of random length, gaps of up to this many cycles (0 = none)
    int sender_max_gap = 0;
    int burst_left     = 0;

    // receiver idling: a 16-bit ready pattern, redrawn each time the 6-bit tick wraps
    logic        sink_stalls = 1'b0;
    logic [15:0] stall_mask  = 16'h0001;
    logic [5:0]  stall_tick  = '0;

    task automatic log_mismatch(input string msg);
        fault_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // add one byte at the end of the line being built
    task automatic append_byte(input logic [eltp_pkg::BYTE_WIDTH-1:0] b);
        line_bytes.insert(line_bytes.size(), b);
    endtask

    // value*10 + digit, wrapping at the id width
    function automatic logic [eltp_pkg::OUT_WIDTH-1:0] shift_in_digit(
        input logic [eltp_pkg::OUT_WIDTH-1:0]  acc,
        input logic [eltp_pkg::BYTE_WIDTH-1:0] ch
    );
        logic [eltp_pkg::BYTE_WIDTH-1:0] digit;
        digit = ch - eltp_pkg::CHAR_ZERO;
        return acc * DECIMAL_BASE +
               {{(eltp_pkg::OUT_WIDTH-eltp_pkg::BYTE_WIDTH){1'b0}}, digit};
    endfunction

    // one accepted byte through the mirror; queues the edge pair it emits, if any
    task automatic advance_parser(input logic [eltp_pkg::BYTE_WIDTH-1:0] ch,
                                  input logic last);
        logic       emit;
        logic       is_num;
        edge_pair_t pair;
        emit   = 1'b0;
        is_num = (ch >= eltp_pkg::CHAR_ZERO) && (ch <= eltp_pkg::CHAR_NINE);
        case (parse_state)
            eltp_pkg::PH_DISCARD:
            begin
                if (ch == eltp_pkg::CHAR_LF)
                    parse_state = eltp_pkg::PH_LINE;
            end
            eltp_pkg::PH_SKIP1:
            begin
                if (is_num)
                begin
                    src_acc     = shift_in_digit('0, ch);
                    parse_state = eltp_pkg::PH_NUM1;
                end
            end
            eltp_pkg::PH_NUM1:
            begin
                if (is_num)
                    src_acc = shift_in_digit(src_acc, ch);
                else
                    parse_state = eltp_pkg::PH_SKIP2;
            end
            eltp_pkg::PH_SKIP2:
            begin
                if (is_num)
                begin
                    dst_acc     = shift_in_digit('0, ch);
                    parse_state = eltp_pkg::PH_NUM2;
                end
            end
            eltp_pkg::PH_NUM2:
            begin
                if (is_num)
                    dst_acc = shift_in_digit(dst_acc, ch);
                else
                begin
                    // the byte that ends the second number emits the edge
                    emit        = 1'b1;
                    parse_state = (ch == eltp_pkg::CHAR_LF) ? eltp_pkg::PH_LINE :
                                                              eltp_pkg::PH_DISCARD;
                end
            end
            default:
            begin
                // line start, also taken by any unused phase code
                if (ch == eltp_pkg::CHAR_LF || ch == eltp_pkg::CHAR_CR ||
                    ch == eltp_pkg::CHAR_SPACE || ch == eltp_pkg::CHAR_TAB)
                    parse_state = eltp_pkg::PH_LINE;
                else if (ch == eltp_pkg::CHAR_PERCENT || ch == eltp_pkg::CHAR_HASH)
                    parse_state = eltp_pkg::PH_DISCARD;
                else
                begin
                    src_acc = '0;
                    dst_acc = '0;
                    if (is_num)
                    begin
                        src_acc     = shift_in_digit('0, ch);
                        parse_state = eltp_pkg::PH_NUM1;
                    end
                    else
                        parse_state = eltp_pkg::PH_SKIP1;
                end
            end
        endcase

        // end of text closes an edge that is still open
        if (last && !emit && parse_state >= eltp_pkg::PH_SKIP1 &&
            parse_state <= eltp_pkg::PH_NUM2)
            emit = 1'b1;

        if (emit)
        begin
            pair.source_id = src_acc;
            pair.dest_id   = dst_acc;
            expected_edges.insert(expected_edges.size(), pair);
        end

        // the next byte starts a new text
        if (last)
        begin
            parse_state = eltp_pkg::PH_LINE;
            src_acc     = '0;
            dst_acc     = '0;
        end
    endtask

    // drive one byte, hold it until the parser takes it, then update the mirror
    task automatic push_text_byte(input logic [eltp_pkg::BYTE_WIDTH-1:0] ch,
                                  input logic last);
        if (sender_max_gap > 0)
        begin
            if (burst_left == 0)
            begin
                // valid drops for a random gap before the next burst
                text_ch.valid <= 1'b0;
                repeat ($urandom_range(1, sender_max_gap)) @(posedge clk);
                burst_left = $urandom_range(1, 16);
            end
            burst_left--;
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= ch;
        text_ch.end_of_text <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        bytes_sent++;
        advance_parser(ch, last);
    endtask

    task automatic push_text(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            push_text_byte(s[i], last_at_end && (i == s.len() - 1));
    endtask

    function automatic logic [eltp_pkg::BYTE_WIDTH-1:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return eltp_pkg::CHAR_SPACE;
            1:       return eltp_pkg::CHAR_TAB;
            2:       return eltp_pkg::CHAR_CR;
            default: return eltp_pkg::CHAR_LF;
        endcase
    endfunction

    function automatic logic [eltp_pkg::BYTE_WIDTH-1:0] pick_letter();
        return CHAR_LOWER_A + eltp_pkg::BYTE_WIDTH'($urandom_range(0, 25));
    endfunction

    function automatic logic [eltp_pkg::BYTE_WIDTH-1:0] pick_separator();
        case ($urandom_range(0, 2))
            0:       return eltp_pkg::CHAR_SPACE;
            1:       return eltp_pkg::CHAR_TAB;
            default: return CHAR_COMMA;
        endcase
    endfunction

    // decimal number, mostly short; some wrap past 32 bits, some hit the top id
    task automatic append_number();
        int kind;
        int len;
        kind = $urandom_range(0, 99);
        if (kind < 4)
        begin
            for (int i = 0; i < MAX_ID_TEXT.len(); i++)
                append_byte(MAX_ID_TEXT[i]);
        end
        else
        begin
            if (kind < 10)
                len = $urandom_range(10, 12);
            else if (kind < 30)
                len = $urandom_range(5, 9);
            else
                len = $urandom_range(1, 4);
            repeat (len)
                append_byte(eltp_pkg::CHAR_ZERO +
                            eltp_pkg::BYTE_WIDTH'($urandom_range(0, 9)));
        end
    endtask

    // one random line: mostly edge lines, some comments, blanks, broken lines and noise
    task automatic build_line();
        int pick;
        line_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 60)
        begin
            repeat ($urandom_range(0, 2))
                append_byte(pick_blank());
            // a letter first opens the edge without a digit
            if ($urandom_range(0, 9) == 0)
                append_byte(pick_letter());
            append_number();
            repeat ($urandom_range(1, 2))
                append_byte(pick_separator());
            append_number();
            // trailing text on the line is dropped by the parser
            if ($urandom_range(0, 3) == 0)
            begin
                append_byte(pick_separator());
                if ($urandom_range(0, 1) == 0)
                    append_number();
                else
                    append_byte(pick_letter());
            end
            if ($urandom_range(0, 4) == 0)
                append_byte(eltp_pkg::CHAR_CR);
            append_byte(eltp_pkg::CHAR_LF);
        end
        else if (pick < 68)
        begin
            append_byte(($urandom_range(0, 1) == 0) ? eltp_pkg::CHAR_PERCENT :
                                                      eltp_pkg::CHAR_HASH);
            repeat ($urandom_range(0, 10))
                append_byte(eltp_pkg::BYTE_WIDTH'($urandom_range(0, 255)));
            append_byte(eltp_pkg::CHAR_LF);
        end
        else if (pick < 74)
        begin
            repeat ($urandom_range(1, 3))
                append_byte(pick_blank());
            append_byte(eltp_pkg::CHAR_LF);
        end
        else if (pick < 85)
        begin
            // broken edge: lone number (dest comes from a later line) or letters only
            if ($urandom_range(0, 1) == 0)
                append_number();
            else
                repeat ($urandom_range(1, 4))
                    append_byte(pick_letter());
            append_byte(eltp_pkg::CHAR_LF);
        end
        else
        begin
            repeat ($urandom_range(1, 8))
                append_byte(eltp_pkg::BYTE_WIDTH'($urandom_range(0, 255)));
        end
    endtask

    // comment lines with both markers, a top byte inside the comment
    task automatic test_comment_lines();
        push_text("%\n#", 1'b0);
        push_text_byte(TOP_BYTE, 1'b0);
        push_text_byte(eltp_pkg::CHAR_LF, 1'b0);
    endtask

    // leading blanks, then the second number taken from a later line
    task automatic test_blank_skip_and_split_number();
        push_text_byte(eltp_pkg::CHAR_SPACE, 1'b0);
        push_text_byte(eltp_pkg::CHAR_TAB, 1'b0);
        push_text_byte(eltp_pkg::CHAR_CR, 1'b0);
        push_text("7\n\n8\n", 1'b0);
    endtask

    // a lone non-digit flagged as last byte gives a (0, 0) edge
    task automatic test_edge_without_digits();
        push_text_byte(NUL_BYTE, 1'b1);
    endtask

    // largest id, end of text inside the first number
    task automatic test_largest_id();
        push_text(MAX_ID_TEXT, 1'b1);
    endtask

    // random text in segments with different idling on both sides
    task automatic test_random_text();
        int seg_end;
        int last_at;
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0:
                begin
                    sender_max_gap = 0;
                    sink_stalls    = 1'b0;
                end
                1:
                begin
                    sender_max_gap = 4;
                    sink_stalls    = 1'b1;
                end
                2:
                begin
                    sender_max_gap = 12;
                    sink_stalls    = 1'b0;
                end
                3:
                begin
                    sender_max_gap = 0;
                    sink_stalls    = 1'b1;
                end
                4:
                begin
                    sender_max_gap = 3;
                    sink_stalls    = 1'b1;
                end
                default:
                begin
                    sender_max_gap = 8;
                    sink_stalls    = 1'b1;
                end
            endcase
            seg_end = bytes_sent + RANDOM_BYTES / SEGMENTS;
            while (bytes_sent < seg_end)
            begin
                build_line();
                // now and then the text ends somewhere inside this line
                last_at = ($urandom_range(0, 19) == 0) ?
                          $urandom_range(0, line_bytes.size() - 1) : -1;
                for (int i = 0; i < line_bytes.size(); i++)
                    push_text_byte(line_bytes[i], i == last_at);
            end
        end
    endtask

    // receiver: ready follows the stall pattern when stalls are on
    always @(posedge clk)
    begin
        if (!rst_n)
            edge_ch.ready <= 1'b0;
        else
        begin
            if (stall_tick == '0)
                stall_mask <= 16'($urandom()) | 16'h0001;
            stall_tick    <= stall_tick + 1'b1;
            edge_ch.ready <= !sink_stalls || stall_mask[stall_tick[3:0]];
        end
    end

    // every edge pair taken is checked against the oldest one owed
    always @(posedge clk)
    begin : check_edges
        edge_pair_t want;
        if (rst_n && edge_ch.valid && edge_ch.ready)
        begin
            if (expected_edges.size() == 0)
                log_mismatch($sformatf("edge (%0d, %0d) with none owed",
                                       edge_ch.source_id, edge_ch.dest_id));
            else
            begin
                want = expected_edges.pop_front();
                if (edge_ch.source_id !== want.source_id)
                    log_mismatch($sformatf("source_id %0d, want %0d",
                                           edge_ch.source_id, want.source_id));
                if (edge_ch.dest_id !== want.dest_id)
                    log_mismatch($sformatf("dest_id %0d, want %0d",
                                           edge_ch.dest_id, want.dest_id));
            end
        end
    end

    // watchdog: too long with no item moving on either channel ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (text_ch.valid && text_ch.ready) || (edge_ch.valid && edge_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: %0d cycles with no item moving", quiet_cycles);
            $display("edge_list_text_parser_unit_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        // known values on every text channel input from time zero
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = '0;
        text_ch.end_of_text = 1'b0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed part with light idling on both sides
        sender_max_gap = 3;
        sink_stalls    = 1'b1;
        test_comment_lines();
        test_blank_skip_and_split_number();
        test_edge_without_digits();
        test_largest_id();

        test_random_text();

        // stop sending, wait for every owed edge, then drain for strays
        text_ch.valid <= 1'b0;
        while (expected_edges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fault_count == 0)
            $display("edge_list_text_parser_unit_tb passed");
        else
            $display("edge_list_text_parser_unit_tb failed");
        $finish;
    end

endmodule

[edge_list_text_parser_unit.f]
rtl/eltp_pkg.sv
rtl/eltp_if.sv
rtl/edge_list_text_parser_unit.sv
bench/edge_list_text_parser_unit_tb.sv
